FILE: rtl/core/fpe_pkg.sv
package fpe_pkg;

  // Datapath commands issued by the controller.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SQUARE,
    CMD_SQRT,
    CMD_DIV,
    CMD_FINISH
  } fpe_cmd_e;

  typedef struct packed {
    fpe_cmd_e   cmd;
    logic [2:0] plane;
    logic [1:0] comp;
    logic [1:0] sq_step;
  } fpe_ctrl_t;

  typedef struct packed {
    logic zero_len;
    logic sqrt_done;
    logic div_done;
  } fpe_stat_t;

  localparam logic [2:0] NumPlanes = 3'd6;
  localparam logic [2:0] FarPlane  = 3'd5;
  localparam logic [1:0] RowLast   = 2'd3;

endpackage

FILE: rtl/core/frustum_plane_extractor_unit.sv
// Channel | Handshake            | Word
// in      | in_valid/in_ready    | row_index_i, elem_{x,y,z,w}_i
// out     | out_valid/out_ready  | plane_id_o, normal_*_o, plane_distance_o, flags
// Rows 0 to 2 are stored while the unit is idle. Row 3 starts six planes in
// turn; each is loaded, its squares are summed, its root is taken bit-serially,
// and four shift-subtract divisions follow, which a zero-length plane skips.
// Input is held off meanwhile.
// Reset clears the row store and the controller. A stalled output word holds
// the sequencer in its emit step.
module frustum_plane_extractor_unit import fpe_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         row_index_i,
  input  logic signed [31:0] elem_x_i,
  input  logic signed [31:0] elem_y_i,
  input  logic signed [31:0] elem_z_i,
  input  logic signed [31:0] elem_w_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         plane_id_o,
  output logic signed [31:0] normal_x_o,
  output logic signed [31:0] normal_y_o,
  output logic signed [31:0] normal_z_o,
  output logic signed [31:0] plane_distance_o,
  output logic               degenerate_o,
  output logic               last_plane_o
);

  fpe_ctrl_t ctrl;
  fpe_stat_t stat;
  logic busy, emit, acc;
  logic signed [31:0] nx, ny, nz, dd;
  logic dg;

  assign in_ready = !busy;
  assign acc      = in_valid && in_ready;

  fpe_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(acc && row_index_i == RowLast),
    .out_free_i(!out_valid || out_ready),
    .stat_i(stat), .ctrl_o(ctrl), .busy_o(busy), .emit_o(emit)
  );

  fpe_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk_i, .rst_ni, .wr_i(acc), .row_i(row_index_i),
    .ex_i(elem_x_i), .ey_i(elem_y_i), .ez_i(elem_z_i), .ew_i(elem_w_i),
    .ctrl_i(ctrl), .stat_o(stat),
    .nx_o(nx), .ny_o(ny), .nz_o(nz), .dist_o(dd), .degen_o(dg)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid        <= 1'b1;
        plane_id_o       <= ctrl.plane;
        normal_x_o       <= nx;
        normal_y_o       <= ny;
        normal_z_o       <= nz;
        plane_distance_o <= dd;
        degenerate_o     <= dg;
        last_plane_o     <= (ctrl.plane == FarPlane);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/fpe_ctrl.sv
module fpe_ctrl import fpe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      out_free_i,
  input  fpe_stat_t stat_i,
  output fpe_ctrl_t ctrl_o,
  output logic      busy_o,
  output logic      emit_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_SQ, ST_SQRT, ST_DIV, ST_EMIT
  } state_e;

  state_e     state_q;
  logic [2:0] plane_q;
  logic [1:0] comp_q, sq_q;
  logic       kick_q;

  assign busy_o = (state_q != ST_IDLE);
  assign emit_o = (state_q == ST_EMIT) && out_free_i;

  // Commands follow directly from the state and counters.
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.plane   = plane_q;
    ctrl_o.comp    = comp_q;
    ctrl_o.sq_step = sq_q;
    unique case (state_q)
      ST_LOAD: ctrl_o.cmd = CMD_LOAD;
      ST_SQ:   ctrl_o.cmd = CMD_SQUARE;
      ST_SQRT: ctrl_o.cmd = kick_q ? CMD_SQRT : CMD_NONE;
      ST_DIV:  ctrl_o.cmd = kick_q ? CMD_DIV : CMD_NONE;
      ST_EMIT: ctrl_o.cmd = emit_o ? CMD_FINISH : CMD_NONE;
      default: ctrl_o.cmd = CMD_NONE;
    endcase
  end

  // Sequence: load plane, square terms, root, four divisions (skipped for a zero-length plane), emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      plane_q <= '0;
      comp_q  <= '0;
      sq_q    <= '0;
      kick_q  <= 1'b0;
    end else begin
      kick_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (start_i) begin
          state_q <= ST_LOAD;
          plane_q <= '0;
        end
        ST_LOAD: begin
          state_q <= ST_SQ;
          sq_q    <= '0;
        end
        ST_SQ: begin
          sq_q <= sq_q + 2'd1;
          if (sq_q == 2'd2) begin
            state_q <= ST_SQRT;
            kick_q  <= 1'b1;
          end
        end
        ST_SQRT: if (!kick_q && stat_i.sqrt_done) begin
          if (stat_i.zero_len) begin
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_DIV;
            comp_q  <= '0;
            kick_q  <= 1'b1;
          end
        end
        ST_DIV: if (!kick_q && stat_i.div_done) begin
          if (comp_q == 2'd3) begin
            state_q <= ST_EMIT;
          end else begin
            comp_q <= comp_q + 2'd1;
            kick_q <= 1'b1;
          end
        end
        ST_EMIT: if (out_free_i) begin
          if (plane_q == FarPlane) begin
            state_q <= ST_IDLE;
          end else begin
            plane_q <= plane_q + 3'd1;
            state_q <= ST_LOAD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/fpe_dpath.sv
module fpe_dpath import fpe_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  logic [1:0]          row_i,
  input  logic signed [31:0]  ex_i,
  input  logic signed [31:0]  ey_i,
  input  logic signed [31:0]  ez_i,
  input  logic signed [31:0]  ew_i,
  input  fpe_ctrl_t           ctrl_i,
  output fpe_stat_t           stat_o,
  output logic signed [31:0]  nx_o,
  output logic signed [31:0]  ny_o,
  output logic signed [31:0]  nz_o,
  output logic signed [31:0]  dist_o,
  output logic                degen_o
);

  localparam int unsigned ShW = 6;
  localparam int unsigned DivN = 33 + FRAC_BITS + 31;

  // Row store: rows 0 to 2 and a copy of row 3.
  logic signed [31:0] rows_q [4][4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) for (int c = 0; c < 4; c++) rows_q[r][c] <= '0;
    end else if (wr_i) begin
      rows_q[row_i][0] <= ex_i;
      rows_q[row_i][1] <= ey_i;
      rows_q[row_i][2] <= ez_i;
      rows_q[row_i][3] <= ew_i;
    end
  end

  // Plane magnitudes and signs.
  logic [32:0] mag_q [4];
  logic        neg_q [4];
  logic        half_q;
  logic [63:0] s_q;
  logic [5:0]  k_q;
  logic [1:0]  src;
  logic [32:0] mag_d [4];
  logic        neg_d [4];

  assign src = ctrl_i.plane[2:1];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic signed [32:0] a, b, p;
      a = {rows_q[RowLast][c][31], rows_q[RowLast][c]};
      b = {rows_q[src][c][31], rows_q[src][c]};
      p = ctrl_i.plane[0] ? a - b : a + b;
      neg_d[c] = p[32];
      mag_d[c] = p[32] ? 33'(-p) : 33'(p);
    end
  end

  // Square terms, one per cycle.
  logic [31:0] sq_in;
  logic [63:0] sq_prod;
  assign sq_in   = mag_q[ctrl_i.sq_step][31:0];
  assign sq_prod = 64'(sq_in) * 64'(sq_in);

  // Square-root unit, one result bit per cycle.
  logic [63:0] sr_rem_q, sr_res_q, sr_bit_q;
  logic        sr_busy_q;
  logic [63:0] l_w;
  assign l_w = sr_res_q;

  // Shift-and-subtract divider.
  logic [DivN-1:0] dv_num_q;
  logic [64:0]     dv_rem_q;
  logic [DivN-1:0] dv_quo_q;
  logic [6:0]      dv_cnt_q;
  logic            dv_busy_q;
  logic [32:0]     dv_cap_q;
  logic [64:0]     dv_r2;
  logic [1:0]      comp_q;

  assign dv_r2 = {dv_rem_q[63:0], dv_num_q[DivN-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_busy_q <= 1'b0;
      dv_busy_q <= 1'b0;
      degen_o   <= 1'b0;
    end else begin
      unique case (ctrl_i.cmd)
        CMD_LOAD: begin
          if (mag_d[0][31] | mag_d[0][32] | mag_d[1][31] | mag_d[1][32]
              | mag_d[2][31] | mag_d[2][32]) begin
            half_q <= 1'b1;
            for (int c = 0; c < 3; c++) mag_q[c] <= mag_d[c] >> 1;
          end else begin
            half_q <= 1'b0;
            for (int c = 0; c < 3; c++) mag_q[c] <= mag_d[c];
          end
          mag_q[3] <= mag_d[3];
          for (int c = 0; c < 4; c++) neg_q[c] <= neg_d[c];
          s_q <= '0;
        end
        CMD_SQUARE: s_q <= s_q + sq_prod;
        CMD_SQRT: begin
          logic [5:0] k;
          k = '0;
          for (int i = 0; i < 31; i++) if ((s_q >> (62 - 2 * i)) == 0) k = 6'(i + 1);
          k_q       <= k;
          sr_rem_q  <= s_q << (2 * k);
          sr_res_q  <= '0;
          sr_bit_q  <= 64'd1 << 62;
          sr_busy_q <= (s_q != 0);
          degen_o   <= (s_q == 0);
        end
        CMD_DIV: begin
          logic [ShW:0] sh;
          sh = 7'(FRAC_BITS) + 7'(k_q) - ((ctrl_i.comp == 2'd3) ? 7'(half_q) : 7'd0);
          comp_q    <= ctrl_i.comp;
          // The numerator enters top bit first; the zeros below it give the scaling.
          dv_num_q  <= {mag_q[ctrl_i.comp], {(DivN - 33){1'b0}}};
          dv_rem_q  <= '0;
          dv_quo_q  <= '0;
          dv_cnt_q  <= 7'(33) + sh;
          dv_busy_q <= 1'b1;
          dv_cap_q  <= (ctrl_i.comp == 2'd3 && !neg_q[3]) ? 33'h7FFFFFFF : 33'h80000000;
        end
        default: ;
      endcase

      // Root iteration.
      if (sr_busy_q) begin
        if (sr_bit_q == 0) begin
          sr_busy_q <= 1'b0;
        end else begin
          if (sr_rem_q >= sr_res_q + sr_bit_q) begin
            sr_rem_q <= sr_rem_q - (sr_res_q + sr_bit_q);
            sr_res_q <= (sr_res_q >> 1) + sr_bit_q;
          end else begin
            sr_res_q <= sr_res_q >> 1;
          end
          sr_bit_q <= sr_bit_q >> 2;
        end
      end

      // Division iteration, with capping and final rounding.
      if (dv_busy_q) begin
        if (dv_cnt_q == 0) begin
          logic [DivN-1:0] q;
          logic [31:0] m, v;
          q = dv_quo_q + DivN'((dv_rem_q << 1) >= 65'(l_w));
          m = (q > DivN'(dv_cap_q)) ? dv_cap_q[31:0] : q[31:0];
          v = neg_q[comp_q] ? -m : m;
          unique case (comp_q)
            2'd0: nx_o <= v;
            2'd1: ny_o <= v;
            2'd2: nz_o <= v;
            default: dist_o <= v;
          endcase
          dv_busy_q <= 1'b0;
        end else begin
          logic            ge, over;
          logic [DivN-1:0] qn;
          ge   = dv_r2 >= 65'(l_w);
          qn   = {dv_quo_q[DivN-2:0], ge};
          over = qn > DivN'(dv_cap_q);
          dv_rem_q <= over ? '0 : (ge ? dv_r2 - 65'(l_w) : dv_r2);
          dv_quo_q <= qn;
          dv_num_q <= dv_num_q << 1;
          dv_cnt_q <= over ? 7'd0 : dv_cnt_q - 7'd1;
        end
      end

      if (ctrl_i.cmd == CMD_SQRT && s_q == 0) begin
        nx_o <= '0; ny_o <= '0; nz_o <= '0; dist_o <= '0;
      end
    end
  end

  assign stat_o.zero_len  = degen_o;
  assign stat_o.sqrt_done = !sr_busy_q;
  assign stat_o.div_done  = !dv_busy_q;

endmodule
